// ----- sv/cascaded_timer_bank_top_macros.svh -----
// Assertion macros used by the timer bank checker.
// Each macro takes a label, an antecedent and a consequent, and expects
// signals named clk and arst_n in the scope where it is used.
`ifndef CASCADED_TIMER_BANK_TOP_MACROS_SVH
`define CASCADED_TIMER_BANK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer bank check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer bank check failed");

`endif

// ----- sv/ctb_pkg.sv -----
`default_nettype none

package ctb_pkg;

	// Fixed field widths.
	localparam int TIMER_SLOTS    = 4;
	localparam int NUM_TIMERS_DEF = 4;
	localparam int COUNT_W        = 16;
	localparam int ELAPSED_W      = 12;
	localparam int REMAIN_W       = 28;
	localparam int DIFF_W         = REMAIN_W + 1;
	localparam int PERIOD_W       = 27;
	localparam int CTL_W          = 8;
	localparam int SHIFT_W        = 4;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 16;

	// Control register bits.
	localparam int CTL_ENABLE_BIT  = 7;
	localparam int CTL_IRQ_BIT     = 6;
	localparam int CTL_CASCADE_BIT = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELOAD_BASE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONTROL_BASE = 4'd4;

	// Prescale select codes.
	localparam logic [1:0] PRESCALE_DIV1    = 2'd0;
	localparam logic [1:0] PRESCALE_DIV64   = 2'd1;
	localparam logic [1:0] PRESCALE_DIV256  = 2'd2;
	localparam logic [1:0] PRESCALE_DIV1024 = 2'd3;

	// Configuration write seen by one timer cell.
	typedef struct packed {
		logic                  reload_we;
		logic                  control_we;
		logic [CFG_DATA_W-1:0] data;
	} ctb_cfg_t;

	// Item as it travels down the row of cells.
	typedef struct packed {
		logic [ELAPSED_W-1:0]                  elapsed;
		logic                                  stop;
		logic [TIMER_SLOTS-1:0]                ovf;
		logic [TIMER_SLOTS-1:0]                irq;
		logic [TIMER_SLOTS-1:0][COUNT_W-1:0]   count;
	} ctb_stage_t;

	// Shift amount for a prescale select.
	function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [1:0] sel);
		logic [SHIFT_W-1:0] sh;
		case (sel)
			PRESCALE_DIV1:    sh = 4'd0;
			PRESCALE_DIV64:   sh = 4'd6;
			PRESCALE_DIV256:  sh = 4'd8;
			PRESCALE_DIV1024: sh = 4'd10;
			default:          sh = 4'd0;
		endcase
		return sh;
	endfunction

	// Timer period: (0x10000 - reload) shifted left by the prescale shift.
	function automatic logic [PERIOD_W-1:0] timer_period(
		input logic [COUNT_W-1:0] reload,
		input logic [1:0]         sel
	);
		logic [COUNT_W:0] ticks;
		ticks = {1'b1, {COUNT_W{1'b0}}} - {1'b0, reload};
		return {{(PERIOD_W-COUNT_W-1){1'b0}}, ticks} << prescale_shift(sel);
	endfunction

endpackage

`default_nettype wire

// ----- sv/ctb_if.sv -----
`default_nettype none

// Elapsed-cycle item channel.
interface ctb_in_if;
	import ctb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed_cycles;
	logic                 stop_mode;

	modport source (output valid, output elapsed_cycles, output stop_mode, input ready);
	modport sink   (input valid, input elapsed_cycles, input stop_mode, output ready);
endinterface

// Timer status result channel.
interface ctb_out_if;
	import ctb_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [COUNT_W-1:0]     count_zero;
	logic [COUNT_W-1:0]     count_one;
	logic [COUNT_W-1:0]     count_two;
	logic [COUNT_W-1:0]     count_three;
	logic [TIMER_SLOTS-1:0] overflow_flags;
	logic [TIMER_SLOTS-1:0] irq_requests;

	modport source (
		output valid, output count_zero, output count_one, output count_two,
		output count_three, output overflow_flags, output irq_requests, input ready
	);
	modport sink (
		input valid, input count_zero, input count_one, input count_two,
		input count_three, input overflow_flags, input irq_requests, output ready
	);
endinterface

`default_nettype wire

// ----- sv/ctb_cell.sv -----
`default_nettype none

// One timer of the bank. It advances its own counter for the item at its
// input, adds its count and flags, and passes the item to the next cell
// through its stage register.
module ctb_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctb_pkg::ctb_cfg_t  cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ctb_pkg::ctb_stage_t in_stage,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ctb_pkg::ctb_stage_t     out_stage
);
	import ctb_pkg::*;

	logic [COUNT_W-1:0]  reload_q;
	logic [CTL_W-1:0]    control_q;
	logic [REMAIN_W-1:0] remain_q;
	logic [COUNT_W-1:0]  count_q;
	logic                valid_q;
	ctb_stage_t          stage_q;

	logic                fire;
	logic                lower_ovf;
	logic                cascade;
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] load_period;
	logic [DIFF_W-1:0]   diff;
	logic                wrapped;
	logic [DIFF_W-1:0]   sum;
	logic [REMAIN_W-1:0] remain_sat;
	logic signed [REMAIN_W-1:0] remain_s;
	logic signed [REMAIN_W-1:0] scaled;
	logic [COUNT_W-1:0]  count_inc;
	logic                step;
	logic [REMAIN_W-1:0] remain_nxt;
	logic [COUNT_W-1:0]  count_nxt;
	logic                hit;
	ctb_stage_t          stage_nxt;

	// A cell takes an item when its stage register is empty or drains.
	assign in_ready  = !valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_stage = stage_q;

	// Overflow of the next lower timer for this same item.
	if (IDX == 0) begin : g_first
		assign lower_ovf = 1'b0;
	end else begin : g_chain
		assign lower_ovf = in_stage.ovf[IDX-1];
	end

	assign cascade     = (IDX != 0) && control_q[CTL_CASCADE_BIT];
	assign period      = timer_period(reload_q, control_q[1:0]);
	assign load_period = timer_period(reload_q, cfg.data[1:0]);

	// Prescaled path: subtract the elapsed cycles, add back one period on wrap,
	// saturate at the most negative remaining count.
	assign diff    = {remain_q[REMAIN_W-1], remain_q}
		- {{(DIFF_W-ELAPSED_W){1'b0}}, in_stage.elapsed};
	assign wrapped = diff[DIFF_W-1] || (diff == '0);
	assign sum     = wrapped ? diff + {{(DIFF_W-PERIOD_W){1'b0}}, period} : diff;

	always_comb begin
		if (sum[DIFF_W-1] && !sum[DIFF_W-2]) begin
			remain_sat = {1'b1, {(REMAIN_W-1){1'b0}}};
		end else begin
			remain_sat = sum[REMAIN_W-1:0];
		end
	end

	// Visible count is 0xFFFF minus the floor-scaled remaining count.
	assign remain_s  = $signed(remain_sat);
	assign scaled    = remain_s >>> prescale_shift(control_q[1:0]);
	assign count_inc = count_q + 1'b1;
	assign step      = fire && !in_stage.stop && control_q[CTL_ENABLE_BIT];

	// Next timer state and this timer's contribution to the item.
	always_comb begin
		remain_nxt = remain_q;
		count_nxt  = count_q;
		hit        = 1'b0;
		if (step) begin
			if (cascade) begin
				if (lower_ovf) begin
					if (count_inc == '0) begin
						count_nxt = reload_q;
						hit       = 1'b1;
					end else begin
						count_nxt = count_inc;
					end
				end
			end else begin
				remain_nxt = remain_sat;
				count_nxt  = ~scaled[COUNT_W-1:0];
				hit        = wrapped;
			end
		end
		stage_nxt            = in_stage;
		stage_nxt.count[IDX] = count_nxt;
		stage_nxt.ovf[IDX]   = hit;
		stage_nxt.irq[IDX]   = hit && control_q[CTL_IRQ_BIT];
	end

	// Timer registers; an enable edge loads a fresh period and the reload value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= '0;
			control_q <= '0;
			remain_q  <= '0;
			count_q   <= '0;
		end else begin
			if (cfg.reload_we) begin
				reload_q <= cfg.data[COUNT_W-1:0];
			end
			if (cfg.control_we) begin
				control_q <= cfg.data[CTL_W-1:0];
				if (!control_q[CTL_ENABLE_BIT] && cfg.data[CTL_ENABLE_BIT]) begin
					remain_q <= {{(REMAIN_W-PERIOD_W){1'b0}}, load_period};
					count_q  <= reload_q;
				end
			end else begin
				remain_q <= remain_nxt;
				count_q  <= count_nxt;
			end
		end
	end

	// Stage register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			stage_q <= stage_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- sv/cascaded_timer_bank_top.sv -----
// Bank of up to four 16-bit timers driven by elapsed-cycle items. Each
// accepted item (elapsed_cycles, stop_mode) advances every enabled timer and
// yields one result with all visible counts and the overflow and interrupt
// bits of that step. Timer n lives in cell n of a row; an item moves one cell
// per clock while the cell ahead of it can take it, passing through the stage
// register of each cell in turn; the stage register of the last cell holds
// the result. A new item is taken every cycle while input ready is high. A
// cascaded timer sees the overflow of the timer below it for the same item,
// handed over with the item between neighboring cells. Stalls on the result
// side fill the empty cells first before input ready drops. Registers are
// written through cfg_we, cfg_index and cfg_data: indexes 0 to 3 are the
// reload values, 4 to 7 the control registers, higher indexes are ignored.
// Write them only while no item is in flight. Setting the enable bit of a
// control register loads the timer with a full period and its reload value.
`default_nettype none

module cascaded_timer_bank_top #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ctb_in_if.sink                             in_ch,
	ctb_out_if.source                          out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [ctb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ctb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ctb_pkg::*;

	ctb_stage_t stage [NUM_TIMERS+1];
	logic       valid [NUM_TIMERS+1];
	logic       ready [NUM_TIMERS+1];

	// Items enter the first cell with no counts and no flags.
	always_comb begin
		stage[0]         = '0;
		stage[0].elapsed = in_ch.elapsed_cycles;
		stage[0].stop    = in_ch.stop_mode;
	end
	assign valid[0]    = in_ch.valid;
	assign in_ch.ready = ready[0];

	// Row of timer cells with their register decode.
	for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_cell
		ctb_cfg_t cfg;

		assign cfg.reload_we  = cfg_we
			&& (cfg_index == CFG_IDX_RELOAD_BASE + CFG_IDX_W'(t));
		assign cfg.control_we = cfg_we
			&& (cfg_index == CFG_IDX_CONTROL_BASE + CFG_IDX_W'(t));
		assign cfg.data       = cfg_data;

		ctb_cell #(
			.IDX (t)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.in_valid  (valid[t]),
			.in_ready  (ready[t]),
			.in_stage  (stage[t]),
			.out_valid (valid[t+1]),
			.out_ready (ready[t+1]),
			.out_stage (stage[t+1])
		);
	end

	// The last cell's stage register is the result register.
	assign ready[NUM_TIMERS]     = out_ch.ready;
	assign out_ch.valid          = valid[NUM_TIMERS];
	assign out_ch.count_zero     = stage[NUM_TIMERS].count[0];
	assign out_ch.count_one      = stage[NUM_TIMERS].count[1];
	assign out_ch.count_two      = stage[NUM_TIMERS].count[2];
	assign out_ch.count_three    = stage[NUM_TIMERS].count[3];
	assign out_ch.overflow_flags = stage[NUM_TIMERS].ovf;
	assign out_ch.irq_requests   = stage[NUM_TIMERS].irq;

endmodule

`default_nettype wire

// ----- sv/ctb_checker.sv -----
`default_nettype none
`include "cascaded_timer_bank_top_macros.svh"

// Port-level checks for the timer bank.
module ctb_checker #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [ctb_pkg::COUNT_W-1:0]     count_zero,
	input wire logic [ctb_pkg::COUNT_W-1:0]     count_one,
	input wire logic [ctb_pkg::COUNT_W-1:0]     count_two,
	input wire logic [ctb_pkg::COUNT_W-1:0]     count_three,
	input wire logic [ctb_pkg::TIMER_SLOTS-1:0] overflow_flags,
	input wire logic [ctb_pkg::TIMER_SLOTS-1:0] irq_requests
);
	import ctb_pkg::*;

	// An interrupt is only raised by a timer that overflowed.
	`CTB_ASSERT_SAME(a_irq_needs_ovf, out_valid, (irq_requests & ~overflow_flags) == '0)

	// Timers past the configured count never report an overflow.
	`CTB_ASSERT_SAME(a_no_ovf_beyond, out_valid, (overflow_flags >> NUM_TIMERS) == '0)

	// Input backpressure only when the whole row is full and the result stalls.
	`CTB_ASSERT_SAME(a_ready_only_full, !in_ready, out_valid && !out_ready)

	// A stalled result holds until its transfer.
	`CTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(count_zero) && $stable(count_one) && $stable(count_two) && $stable(count_three) && $stable(overflow_flags) && $stable(irq_requests))

endmodule

bind cascaded_timer_bank_top ctb_checker #(
	.NUM_TIMERS (NUM_TIMERS)
) u_ctb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.count_zero     (out_ch.count_zero),
	.count_one      (out_ch.count_one),
	.count_two      (out_ch.count_two),
	.count_three    (out_ch.count_three),
	.overflow_flags (out_ch.overflow_flags),
	.irq_requests   (out_ch.irq_requests)
);

`default_nettype wire
